// File: design/ahdlc_pkg.sv
// ----------------------------------------------------------------------------
// ahdlc_pkg
// Shared types, constants and functions of the async HDLC receive deframer.
// ----------------------------------------------------------------------------
package ahdlc_pkg;

  localparam int unsigned DEF_FRAME_LIMIT = 4096;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam int unsigned CNT_W  = 13;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0]  FLAG_CHAR = 8'h7e;
  localparam logic [7:0]  ESC_CHAR  = 8'h7d;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [7:0]  ADDR_CHAR = 8'hff;
  localparam logic [7:0]  CTRL_CHAR = 8'h03;
  localparam logic [7:0]  PROTO_PAD = 8'h00;
  localparam logic [15:0] FCS_INIT  = 16'hffff;
  localparam logic [15:0] FCS_GOOD  = 16'hf0b8;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  localparam logic [CNT_W-1:0] MAX_FRAME_RESET = 13'd1506;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_RX_ACCM     = 2'd0;
  localparam logic [1:0] REG_ACCEPT_ACFC = 2'd1;
  localparam logic [1:0] REG_ACCEPT_PFC  = 2'd2;
  localparam logic [1:0] REG_MAX_FRAME   = 2'd3;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_FCS_ERR = 3'd2,
    KIND_SHORT   = 3'd3,
    KIND_DROPPED = 3'd4,
    KIND_ABORT   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [31:0]      rx_accm;
    logic             accept_acfc;
    logic             accept_pfc;
    logic [CNT_W-1:0] max_frame_bytes;
  } cfg_t;

  // Up to two results caused by one line byte
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] data0;
    kind_t      kind0;
    logic [7:0] data1;
    kind_t      kind1;
    logic [3:0] status;
  } entry_t;

  function automatic logic [15:0] fcs_update(logic [15:0] fcs, logic [7:0] c);
    logic [15:0] f;
    f = fcs ^ {8'h00, c};
    for (int i = 0; i < 8; i++) begin
      f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

endpackage

// File: design/ahdlc_ifs.sv
// ----------------------------------------------------------------------------
// ahdlc interfaces
// Valid/ready channels for received line bytes and deframed results.
// ----------------------------------------------------------------------------
interface ahdlc_rx_if ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ahdlc_res_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic [3:0] line_status;
  logic       last_of_step;

  modport source (output valid, output out_byte, output kind, output line_status,
                  output last_of_step, input ready);
  modport sink (input valid, input out_byte, input kind, input line_status,
                input last_of_step, output ready);
endinterface

// File: design/ahdlc_cfg.sv
// ----------------------------------------------------------------------------
// ahdlc_cfg
// APB-style configuration registers of the deframer.
// ----------------------------------------------------------------------------
module ahdlc_cfg import ahdlc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] index;
  logic       wr_en;

  assign index  = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_accm         <= '0;
      cfg.accept_acfc     <= 1'b1;
      cfg.accept_pfc      <= 1'b1;
      cfg.max_frame_bytes <= MAX_FRAME_RESET;
    end else if (wr_en) begin
      case (index)
        REG_RX_ACCM:     cfg.rx_accm         <= pwdata;
        REG_ACCEPT_ACFC: cfg.accept_acfc     <= pwdata[0];
        REG_ACCEPT_PFC:  cfg.accept_pfc      <= pwdata[0];
        REG_MAX_FRAME:   cfg.max_frame_bytes <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_RX_ACCM:     prdata = cfg.rx_accm;
      REG_ACCEPT_ACFC: prdata = DATA_W'(cfg.accept_acfc);
      REG_ACCEPT_PFC:  prdata = DATA_W'(cfg.accept_pfc);
      REG_MAX_FRAME:   prdata = DATA_W'(cfg.max_frame_bytes);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: design/ahdlc_front.sv
// ----------------------------------------------------------------------------
// ahdlc_front
// Per-byte classification: control map, unescape, header check, FCS, hold.
// ----------------------------------------------------------------------------
module ahdlc_front import ahdlc_pkg::*; #(
  parameter int unsigned FRAME_LIMIT = DEF_FRAME_LIMIT
) (
  input  logic       clk,
  input  logic       rst,
  ahdlc_rx_if.sink   line,
  input  cfg_t       cfg,
  input  logic       enq_full,
  output logic       enq_valid,
  output entry_t     enq_entry
);

  localparam int unsigned LimW = ($clog2(FRAME_LIMIT + 1) > CNT_W) ?
                                 $clog2(FRAME_LIMIT + 1) : CNT_W;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [1:0]       fill;
    logic [7:0]       h0;
    logic [7:0]       h1;
    logic [1:0]       n;
    logic [1:0][7:0]  rb;
    kind_t [1:0]      rk;
  } st_t;

  logic [CNT_W-1:0] stored_count;
  logic [15:0]      running_fcs;
  logic             escape_pending;
  logic             flushing;
  logic [7:0]       hold0;
  logic [7:0]       hold1;
  logic [1:0]       hold_fill;
  logic [3:0]       line_flags;

  logic [15:0] running_fcs_next;
  logic        escape_pending_next;
  logic        flushing_next;
  logic [3:0]  line_flags_next;
  st_t         st_next;
  logic        accept;

  function automatic st_t emit_r(st_t s, logic [7:0] b, kind_t k);
    st_t r;
    r = s;
    if (r.n == 2'd0) begin
      r.rb[0] = b;
      r.rk[0] = k;
    end else begin
      r.rb[1] = b;
      r.rk[1] = k;
    end
    if (r.n != 2'd2) r.n = r.n + 2'd1;
    return r;
  endfunction

  function automatic st_t push_r(st_t s, logic [7:0] b);
    st_t r;
    r = s;
    if (r.fill == 2'd2) begin
      r    = emit_r(r, r.h0, KIND_DATA);
      r.h0 = r.h1;
      r.h1 = b;
    end else if (r.fill == 2'd0) begin
      r.h0   = b;
      r.fill = 2'd1;
    end else begin
      r.h1   = b;
      r.fill = 2'd2;
    end
    r.cnt = r.cnt + CNT_W'(1);
    return r;
  endfunction

  function automatic st_t flush_r(st_t s);
    st_t r;
    r      = s;
    r.cnt  = '0;
    r.fill = 2'd0;
    return emit_r(r, 8'h00, KIND_DROPPED);
  endfunction

  assign line.ready = !enq_full;
  assign accept     = line.valid && line.ready;

  always_comb begin
    st_t              s;
    logic             go;
    logic [7:0]       c;
    logic [7:0]       cc;
    logic [CNT_W-1:0] adj;

    c       = line.rx_byte;
    s.cnt   = stored_count;
    s.fill  = hold_fill;
    s.h0    = hold0;
    s.h1    = hold1;
    s.n     = 2'd0;
    s.rb    = '0;
    s.rk[0] = KIND_DATA;
    s.rk[1] = KIND_DATA;
    go      = 1'b0;
    cc      = c;
    adj     = '0;

    running_fcs_next    = running_fcs;
    escape_pending_next = escape_pending;
    flushing_next       = flushing;
    line_flags_next     = line_flags | {(^c) ? 2'b01 : 2'b10, c[7] ? 2'b01 : 2'b10};

    if (!(c[7:5] == 3'd0 && cfg.rx_accm[c[4:0]])) begin
      if (c == FLAG_CHAR) begin
        if (flushing) begin
          flushing_next = 1'b0;
        end else if (escape_pending) begin
          if (s.cnt != '0) s = emit_r(s, 8'h00, KIND_ABORT);
        end else if (s.cnt != '0) begin
          // strip the FCS before the length check
          adj = (s.cnt > CNT_W'(2)) ? s.cnt - CNT_W'(2) : s.cnt;
          if (adj < CNT_W'(4)) begin
            s = emit_r(s, 8'h00, KIND_SHORT);
          end else begin
            s = emit_r(s, 8'h00, (running_fcs == FCS_GOOD) ? KIND_GOOD : KIND_FCS_ERR);
          end
        end
        escape_pending_next = 1'b0;
        s.cnt               = '0;
        s.fill              = 2'd0;
      end else if (!flushing) begin
        go = 1'b1;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          cc                  = c ^ ESC_XOR;
        end else if (c == ESC_CHAR) begin
          escape_pending_next = 1'b1;
          go                  = 1'b0;
        end
        if (go && s.cnt == CNT_W'(0)) begin
          running_fcs_next = FCS_INIT;
          if (cc != ADDR_CHAR) begin
            if (!cfg.accept_acfc) begin
              s  = flush_r(s);
              go = 1'b0;
            end else begin
              s = push_r(s, ADDR_CHAR);
              s = push_r(s, CTRL_CHAR);
            end
          end
        end
        if (go && s.cnt == CNT_W'(1) && cc != CTRL_CHAR) begin
          s  = flush_r(s);
          go = 1'b0;
        end
        if (go && s.cnt == CNT_W'(2) && cc[0]) begin
          if (!cfg.accept_pfc) begin
            s  = flush_r(s);
            go = 1'b0;
          end else begin
            s = push_r(s, PROTO_PAD);
          end
        end
        if (go && s.cnt == CNT_W'(3) && !cc[0]) begin
          s  = flush_r(s);
          go = 1'b0;
        end
        // overrun: the limit is the smaller of the register and FRAME_LIMIT
        if (go && (s.cnt >= cfg.max_frame_bytes ||
                   LimW'(s.cnt) >= LimW'(FRAME_LIMIT))) begin
          s  = flush_r(s);
          go = 1'b0;
        end
        if (go) begin
          s                = push_r(s, cc);
          running_fcs_next = fcs_update(running_fcs_next, cc);
        end else if (s.n != 2'd0 && c != ESC_CHAR) begin
          flushing_next = 1'b1;
        end else if (s.n != 2'd0) begin
          flushing_next = 1'b1;
        end
      end
    end

    st_next = s;
  end

  assign enq_valid        = accept && st_next.n != 2'd0;
  assign enq_entry.count  = st_next.n;
  assign enq_entry.data0  = st_next.rb[0];
  assign enq_entry.kind0  = st_next.rk[0];
  assign enq_entry.data1  = st_next.rb[1];
  assign enq_entry.kind1  = st_next.rk[1];
  assign enq_entry.status = line_flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count   <= '0;
      running_fcs    <= FCS_INIT;
      escape_pending <= 1'b0;
      flushing       <= 1'b0;
      hold_fill      <= 2'd0;
      line_flags     <= 4'd0;
    end else if (accept) begin
      stored_count   <= st_next.cnt;
      running_fcs    <= running_fcs_next;
      escape_pending <= escape_pending_next;
      flushing       <= flushing_next;
      hold_fill      <= st_next.fill;
      line_flags     <= line_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold0 <= st_next.h0;
      hold1 <= st_next.h1;
    end
  end

endmodule

// File: design/ahdlc_queue.sv
// ----------------------------------------------------------------------------
// ahdlc_queue
// Short FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module ahdlc_queue import ahdlc_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            slots [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;

  assign full       = fill == CntW'(DEPTH);
  assign head_valid = fill != '0;
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CntW'(1);
        2'b01:   fill <= fill - CntW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

// File: design/ahdlc_back.sv
// ----------------------------------------------------------------------------
// ahdlc_back
// Serializes queued entries into single results through an output register.
// ----------------------------------------------------------------------------
module ahdlc_back import ahdlc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  entry_t        head_entry,
  output logic          pop,
  ahdlc_res_if.source   frame
);

  logic       sel;
  logic       cur_last;
  logic       load;
  logic [7:0] cur_data;
  kind_t      cur_kind;

  assign cur_data = sel ? head_entry.data1 : head_entry.data0;
  assign cur_kind = sel ? head_entry.kind1 : head_entry.kind0;
  assign cur_last = sel || head_entry.count == 2'd1;
  assign load     = head_valid && (!frame.valid || frame.ready);
  assign pop      = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
      sel         <= 1'b0;
    end else if (load) begin
      frame.valid <= 1'b1;
      sel         <= !cur_last;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame.out_byte     <= cur_data;
      frame.kind         <= cur_kind;
      frame.line_status  <= head_entry.status;
      frame.last_of_step <= cur_last;
    end
  end

endmodule

// File: design/async_hdlc_rx_deframer_core.sv
// ----------------------------------------------------------------------------
// async_hdlc_rx_deframer_core
// Async HDLC receive deframer with header restore and FCS-16 check.
// ----------------------------------------------------------------------------
// Line bytes enter on the line channel (valid/ready, rx_byte). Each byte gives
// zero, one or two results on the frame channel: data words (kind 0) and one
// end word per frame (good, FCS error, short, dropped, aborted); last_of_step
// marks the final word caused by a byte, line_status carries the sticky flags.
// The front takes one byte per cycle while the queue is not full, classifying
// it in that cycle; its results enter a QUEUE_DEPTH-entry queue, and the back
// part drives one word per cycle from an output register while the receiver
// is ready. A result word passes through the queue and the output register.
// Sustained rate is one byte per cycle while the receiver is ready; a byte that
// restores the protocol zero yields two words. When the receiver stalls, the
// queue fills and line.ready drops once it is full. Reset clears frame state,
// line flags and the queue, and loads the registers with their defaults (map 0,
// both compressions accepted, 1506 bytes). The user must write the registers
// over the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module async_hdlc_rx_deframer_core import ahdlc_pkg::*; #(
  parameter int unsigned FRAME_LIMIT = DEF_FRAME_LIMIT,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  ahdlc_rx_if.sink          line,
  ahdlc_res_if.source       frame,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  logic   enq_full;
  logic   enq_valid;
  entry_t enq_entry;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  ahdlc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ahdlc_front #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .line      (line),
    .cfg       (cfg),
    .enq_full  (enq_full),
    .enq_valid (enq_valid),
    .enq_entry (enq_entry)
  );

  ahdlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (enq_valid),
    .push_entry (enq_entry),
    .full       (enq_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  ahdlc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .frame      (frame)
  );

endmodule

// File: tb/async_hdlc_rx_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_hdlc_rx_deframer_core_tb
// Streams received line bytes into the deframer: sealed frames with escapes,
// compressed headers, discarded control characters, aborts, truncations,
// corrupted bytes and line noise, under several register settings. A local
// model of the deframer predicts every result word, and a monitor compares
// each word field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module async_hdlc_rx_deframer_core_tb;
  import ahdlc_pkg::*;

  localparam int unsigned FRAME_CAP     = DEF_FRAME_LIMIT;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          LONG_STALL    = 300;
  localparam int          IDLE_LIMIT    = 3000;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic [3:0] status;
    logic       last;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ahdlc_rx_if  line_ch ();
  ahdlc_res_if frame_ch ();

  logic              send_valid = 1'b0;
  logic [7:0]        send_byte  = 8'h00;
  logic              take_ready = 1'b0;
  logic              apb_sel    = 1'b0;
  logic              apb_enable = 1'b0;
  logic              apb_write  = 1'b0;
  logic [ADDR_W-1:0] apb_addr   = '0;
  logic [DATA_W-1:0] apb_wdata  = '0;
  logic [DATA_W-1:0] apb_rdata;
  logic              apb_ready;

  assign line_ch.valid   = send_valid;
  assign line_ch.rx_byte = send_byte;
  assign frame_ch.ready  = take_ready;

  async_hdlc_rx_deframer_core u_top (
    .clk     (clk),
    .rst     (rst),
    .line    (line_ch),
    .frame   (frame_ch),
    .psel    (apb_sel),
    .penable (apb_enable),
    .pwrite  (apb_write),
    .paddr   (apb_addr),
    .pwdata  (apb_wdata),
    .prdata  (apb_rdata),
    .pready  (apb_ready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Deframer model: registers and frame state
  logic [31:0]  cfg_accm   = 32'h0;
  logic         cfg_acfc   = 1'b1;
  logic         cfg_pfc    = 1'b1;
  logic [12:0]  cfg_max    = MAX_FRAME_RESET;
  int unsigned  stored_len = 0;
  logic [15:0]  crc_acc    = FCS_INIT;
  logic         esc_armed  = 1'b0;
  logic         flushing   = 1'b0;
  logic [7:0]   hold_buf [2];
  int           hold_cnt   = 0;
  logic [3:0]   flags      = 4'h0;

  word_t        step_words[$];
  word_t        expected_words[$];
  logic [7:0]   line_bytes[$];
  logic [7:0]   frame_body[$];

  int  items_sent      = 0;
  int  words_seen      = 0;
  int  errors          = 0;
  int  idle_cycles     = 0;
  int  send_gap        = 0;
  int  stall_left      = 0;
  int  next_long_stall = 150;
  bit  no_idle         = 1'b0;
  logic line_took      = 1'b0;

  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ FCS_POLY;
    end
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic emit_word(input logic [7:0] b, input kind_t k);
    word_t w;
    w.data   = b;
    w.kind   = k;
    w.status = flags;
    w.last   = 1'b0;
    step_words.push_back(w);
  endtask

  // The last two stored bytes stay in the hold, so the FCS never comes out
  task automatic store_byte(input logic [7:0] b);
    if (hold_cnt >= 2) begin
      emit_word(hold_buf[0], KIND_DATA);
      hold_buf[0] = hold_buf[1];
      hold_buf[1] = b;
    end else begin
      hold_buf[hold_cnt] = b;
      hold_cnt++;
    end
    stored_len++;
  endtask

  task automatic begin_flush();
    flushing   = 1'b1;
    stored_len = 0;
    hold_cnt   = 0;
    emit_word(8'h00, KIND_DROPPED);
  endtask

  task automatic close_frame();
    int unsigned cnt;
    cnt = stored_len;
    if (flushing) begin
      flushing = 1'b0;
    end else if (esc_armed) begin
      if (cnt != 0) emit_word(8'h00, KIND_ABORT);
    end else if (cnt != 0) begin
      if (cnt > 2) cnt -= 2;
      if (cnt < 4) emit_word(8'h00, KIND_SHORT);
      else emit_word(8'h00, (crc_acc == FCS_GOOD) ? KIND_GOOD : KIND_FCS_ERR);
    end
    esc_armed  = 1'b0;
    stored_len = 0;
    hold_cnt   = 0;
  endtask

  task automatic absorb_byte(input logic [7:0] raw);
    logic [7:0]  c;
    int unsigned lim;
    c   = raw;
    lim = (cfg_max < FRAME_CAP) ? cfg_max : FRAME_CAP;
    if (esc_armed) begin
      esc_armed = 1'b0;
      c = c ^ ESC_XOR;
    end else if (c == ESC_CHAR) begin
      esc_armed = 1'b1;
      return;
    end
    if (stored_len == 0) begin
      crc_acc = FCS_INIT;
      if (c != ADDR_CHAR) begin
        if (!cfg_acfc) begin
          begin_flush();
          return;
        end
        store_byte(ADDR_CHAR);
        store_byte(CTRL_CHAR);
      end
    end
    if (stored_len == 1 && c != CTRL_CHAR) begin
      begin_flush();
      return;
    end
    if (stored_len == 2 && c[0]) begin
      if (!cfg_pfc) begin
        begin_flush();
        return;
      end
      store_byte(PROTO_PAD);
    end
    if ((stored_len == 3 && !c[0]) || stored_len >= lim) begin
      begin_flush();
      return;
    end
    store_byte(c);
    crc_acc = crc16_next(crc_acc, c);
  endtask

  task automatic predict_line_byte(input logic [7:0] c);
    step_words.delete();
    flags |= c[7] ? 4'b0001 : 4'b0010;
    flags |= (^c) ? 4'b0100 : 4'b1000;
    if (c < 8'h20 && cfg_accm[c[4:0]]) return;
    if (c == FLAG_CHAR) close_frame();
    else if (!flushing) absorb_byte(c);
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  // Predict on accepted line bytes, check accepted result words
  always @(posedge clk) begin : watch_channels
    word_t w;
    if (!rst) begin
      line_took <= line_ch.valid && line_ch.ready;
      if ((line_ch.valid && line_ch.ready) || (frame_ch.valid && frame_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (frame_ch.valid && frame_ch.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte %02h kind %0d", frame_ch.out_byte, frame_ch.kind);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (frame_ch.out_byte !== w.data) begin
            $error("out_byte: expected %02h, got %02h", w.data, frame_ch.out_byte);
            errors++;
          end
          if (frame_ch.kind !== w.kind) begin
            $error("kind: expected %0d, got %0d", w.kind, frame_ch.kind);
            errors++;
          end
          if (frame_ch.line_status !== w.status) begin
            $error("line_status: expected %h, got %h", w.status, frame_ch.line_status);
            errors++;
          end
          if (frame_ch.last_of_step !== w.last) begin
            $error("last_of_step: expected %0d, got %0d", w.last, frame_ch.last_of_step);
            errors++;
          end
        end
      end
      if (line_ch.valid && line_ch.ready) predict_line_byte(line_ch.rx_byte);
    end
  end

  // Line side: advance to the next byte once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
    end else if (!send_valid || line_took) begin
      if (send_gap > 0) begin
        send_valid <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (line_bytes.size() > 0) begin
        send_byte  <= line_bytes.pop_front();
        send_valid <= 1'b1;
        send_gap   <= no_idle ? 0 : idle_len();
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      take_ready <= 1'b0;
    end else if (stall_left > 0) begin
      take_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (words_seen >= next_long_stall) begin
      take_ready      <= 1'b0;
      stall_left      <= LONG_STALL;
      next_long_stall <= next_long_stall + 600;
    end else begin
      take_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  task automatic put(input logic [7:0] b);
    line_bytes.push_back(b);
    items_sent++;
  endtask

  // Slip in a control character that the receive map discards
  task automatic maybe_junk();
    int j;
    if (cfg_accm == 32'h0 || $urandom_range(0, 19) != 0) return;
    do j = $urandom_range(0, 31); while (!cfg_accm[j]);
    line_bytes.push_back(8'(j));
  endtask

  task automatic send_escaped(input logic [7:0] b);
    logic need;
    need = (b == FLAG_CHAR) || (b == ESC_CHAR) || (b < 8'h20 && cfg_accm[b[4:0]]);
    // gratuitous escapes only where the escaped form is not a flag or a mapped control character
    if (!need && (b < 8'h20 || b >= 8'h40) && b != 8'h5e && $urandom_range(0, 15) == 0)
      need = 1'b1;
    maybe_junk();
    if (need) begin
      put(ESC_CHAR);
      maybe_junk();
      put(b ^ ESC_XOR);
    end else begin
      put(b);
    end
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return FLAG_CHAR;
      1:       return ESC_CHAR;
      2:       return 8'h5e;
      3:       return 8'h00;
      4:       return 8'hff;
      5:       return 8'($urandom_range(0, 31));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Append the FCS to frame_body, optionally damage it, then send it
  task automatic send_body(input bit mangle);
    logic [15:0] f;
    int          r;
    int          k;
    int          keep;
    f = FCS_INIT;
    foreach (frame_body[i]) f = crc16_next(f, frame_body[i]);
    f = ~f;
    frame_body.push_back(f[7:0]);
    frame_body.push_back(f[15:8]);
    r = mangle ? $urandom_range(0, 99) : 99;
    if (r < 8) begin
      k = $urandom_range(0, frame_body.size() - 1);
      frame_body[k] = frame_body[k] ^ (8'h01 << $urandom_range(0, 7));
    end else if (r < 12) begin
      keep = $urandom_range(0, frame_body.size() - 1);
      while (frame_body.size() > keep) void'(frame_body.pop_back());
    end else if (r < 15) begin
      frame_body[$urandom_range(0, 1)] = 8'($urandom);
    end
    foreach (frame_body[i]) send_escaped(frame_body[i]);
    if (r >= 15 && r < 19) begin
      maybe_junk();
      put(ESC_CHAR);
    end
    maybe_junk();
    put(FLAG_CHAR);
  endtask

  task automatic random_frame(input int plen);
    frame_body.delete();
    if (!cfg_acfc || $urandom_range(0, 2) != 0) begin
      frame_body.push_back(ADDR_CHAR);
      frame_body.push_back(CTRL_CHAR);
    end
    if (cfg_pfc && $urandom_range(0, 1)) begin
      frame_body.push_back(8'($urandom) | 8'h01);
    end else begin
      frame_body.push_back(8'($urandom) & 8'hfe);
      frame_body.push_back(8'($urandom) | 8'h01);
    end
    repeat (plen) frame_body.push_back(pick_payload());
    send_body(1'b1);
  endtask

  // Hold the sender until every expected word has come out
  task automatic settle();
    while (line_bytes.size() != 0 || send_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_traffic(input int target);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        random_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12));
      end else if (r < 94) begin
        repeat ($urandom_range(1, 6)) put(pick_payload());
        if ($urandom_range(0, 1)) put(FLAG_CHAR);
      end else if (r < 96) begin
        settle();
      end else begin
        put(FLAG_CHAR);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd_exp;
    @(negedge clk);
    apb_sel    = 1'b1;
    apb_enable = 1'b0;
    apb_write  = 1'b1;
    apb_addr   = {idx, 2'b00};
    apb_wdata  = val;
    @(negedge clk);
    apb_enable = 1'b1;
    @(posedge clk);
    while (!apb_ready) @(posedge clk);
    @(negedge clk);
    apb_sel    = 1'b0;
    apb_enable = 1'b0;
    apb_write  = 1'b0;
    rd_exp     = '0;
    case (idx)
      REG_RX_ACCM: begin
        cfg_accm = val;
        rd_exp   = val;
      end
      REG_ACCEPT_ACFC: begin
        cfg_acfc = val[0];
        rd_exp   = {31'h0, val[0]};
      end
      REG_ACCEPT_PFC: begin
        cfg_pfc = val[0];
        rd_exp  = {31'h0, val[0]};
      end
      REG_MAX_FRAME: begin
        cfg_max = val[12:0];
        rd_exp  = {19'h0, val[12:0]};
      end
      default: ;
    endcase
    if (apb_rdata !== rd_exp) begin
      $error("prdata: expected %h, got %h", rd_exp, apb_rdata);
      errors++;
    end
  endtask

  task automatic set_config(input logic [31:0] accm, input logic acfc, input logic pfc,
                            input logic [12:0] max_bytes);
    write_reg(REG_RX_ACCM, accm);
    write_reg(REG_ACCEPT_ACFC, {31'h0, acfc});
    write_reg(REG_ACCEPT_PFC, {31'h0, pfc});
    write_reg(REG_MAX_FRAME, {19'h0, max_bytes});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty flag, short frame with both headers restored
    put(FLAG_CHAR);
    put(8'h00);
    put(FLAG_CHAR);
    // good frame, compressed header, flag and escape characters in the data
    frame_body = {8'h21, FLAG_CHAR, ESC_CHAR, 8'h00, 8'hff};
    send_body(1'b0);
    // abort, then a bad control byte that flushes until the next flag
    put(ADDR_CHAR);
    put(ESC_CHAR);
    put(FLAG_CHAR);
    put(ADDR_CHAR);
    put(8'h05);
    put(8'h12);
    put(FLAG_CHAR);
    // FCS error
    put(ADDR_CHAR);
    put(CTRL_CHAR);
    put(8'h00);
    put(8'h21);
    put(8'haa);
    put(8'hbb);
    put(FLAG_CHAR);
    random_traffic(150);
    settle();

    // every control character escaped, no compression, one overrun frame
    set_config(32'hffff_ffff, 1'b0, 1'b0, 13'd256);
    random_traffic(150);
    frame_body = {ADDR_CHAR, CTRL_CHAR, 8'h00, 8'h21};
    repeat (270) frame_body.push_back(8'($urandom));
    send_body(1'b0);
    random_traffic(40);
    settle();

    // limit above the frame cap, no random idling on either side
    no_idle = 1'b1;
    set_config($urandom, 1'b1, 1'b0, 13'h1fff);
    random_traffic(150);
    settle();
    no_idle = 1'b0;

    // zero limit: every stored byte overruns
    set_config($urandom, 1'b0, 1'b1, 13'd0);
    random_traffic(30);
    settle();

    // tiny limit: overrun near the header and near the FCS
    set_config($urandom, 1'b1, 1'b1, 13'd12);
    random_traffic(150);
    settle();

    set_config(32'h0, 1'b1, 1'b1, 13'd4096);
    random_traffic(150);
    settle();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
